// ===== hw/rtl/lbp_pkg.sv =====
// ----------------------------------------------------------------------------
// LBP package
// Shared types, constants and the 3x3 pattern function for the LBP stream core.
// ----------------------------------------------------------------------------
package lbp_pkg;

  // Payload widths
  localparam int PIX_W      = 8;
  localparam int POS_W      = 10;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // Register reset values
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  // Neighbour bit masks, bit0 top-left, clockwise to bit7 left
  localparam logic [PIX_W-1:0] K8_01 = 8'h01;
  localparam logic [PIX_W-1:0] K8_02 = 8'h02;
  localparam logic [PIX_W-1:0] K8_04 = 8'h04;
  localparam logic [PIX_W-1:0] K8_08 = 8'h08;
  localparam logic [PIX_W-1:0] K8_10 = 8'h10;
  localparam logic [PIX_W-1:0] K8_20 = 8'h20;
  localparam logic [PIX_W-1:0] K8_40 = 8'h40;
  localparam logic [PIX_W-1:0] K8_80 = 8'h80;

  // Result slots of one descriptor, emitted in this order
  localparam int NUM_SLOTS       = 4;
  localparam int SLOT_ABOVE_PREV = 0;  // (row-1, col-1), carries the code
  localparam int SLOT_ABOVE_END  = 1;  // (row-1, col), right border
  localparam int SLOT_LAST_PREV  = 2;  // (row, col-1), bottom border
  localparam int SLOT_CUR        = 3;  // (row, col), top or corner border

  // Descriptor queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [PIX_W-1:0]     code;
    logic [POS_W-1:0]     row;
    logic [POS_W-1:0]     col;
    logic [NUM_SLOTS-1:0] slots;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic afull;  // one free entry or less
  } q_status_t;

  function automatic logic [PIX_W-1:0] lbp_code(input win_t w);
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] v;
    ctr = w[4];
    v   = '0;
    if (w[0] >= ctr) v = v | K8_01;
    if (w[1] >= ctr) v = v | K8_02;
    if (w[2] >= ctr) v = v | K8_04;
    if (w[5] >= ctr) v = v | K8_08;
    if (w[8] >= ctr) v = v | K8_10;
    if (w[7] >= ctr) v = v | K8_20;
    if (w[6] >= ctr) v = v | K8_40;
    if (w[3] >= ctr) v = v | K8_80;
    return v;
  endfunction

endpackage

// ===== hw/rtl/lbp_front.sv =====
// ----------------------------------------------------------------------------
// LBP front end
// Accepts pixels, runs the line store and 3x3 window, classifies each pixel
// into a result descriptor and pushes it to the queue.
// ----------------------------------------------------------------------------
module lbp_front
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_i,
  input  q_status_t             q_stat_i,
  output logic                  push_o,
  output desc_t                 desc_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int RST_W = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int RST_H = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  logic [CW-1:0] wlast_q, wlast_d;
  logic [RW-1:0] hlast_q, hlast_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          restart;
  logic          acc;

  logic             b_valid_q;
  logic [PIX_W-1:0] b_px_q;
  logic [CW-1:0]    b_col_q;
  logic [RW-1:0]    b_row_q;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  win_t win_q, win_s;
  logic top, mid, bot, at_end;

  assign in_ready_o = !q_stat_i.full && !(q_stat_i.afull && b_valid_q);
  assign acc        = in_valid_i && in_ready_o;

  // Register writes, clamped to the supported range
  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH: begin
          restart = 1'b1;
          if (cfg_wdata_i < CFG_DATA_W'(3)) wlast_d = CW'(2);
          else if (32'(cfg_wdata_i) > MAX_WIDTH) wlast_d = CW'(MAX_WIDTH - 1);
          else wlast_d = CW'(cfg_wdata_i - CFG_DATA_W'(1));
        end
        CFG_FRAME_HEIGHT: begin
          restart = 1'b1;
          if (cfg_wdata_i < CFG_DATA_W'(2)) hlast_d = RW'(1);
          else if (32'(cfg_wdata_i) > MAX_HEIGHT) hlast_d = RW'(MAX_HEIGHT - 1);
          else hlast_d = RW'(cfg_wdata_i - CFG_DATA_W'(1));
        end
        default: ;
      endcase
    end
  end

  // Raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (acc) begin
      if (col_q == wlast_q) begin
        col_d = '0;
        row_d = (row_q == hlast_q) ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q   <= CW'(RST_W - 1);
      hlast_q   <= RW'(RST_H - 1);
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
      win_q     <= '0;
    end else begin
      wlast_q   <= wlast_d;
      hlast_q   <= hlast_d;
      col_q     <= col_d;
      row_q     <= row_d;
      b_valid_q <= acc;
      if (b_valid_q) win_q <= win_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      b_px_q  <= pixel_i;
      b_col_q <= col_q;
      b_row_q <= row_q;
    end
  end

  // Line store: entry holds {two rows above, one row above}; write lags read
  always_ff @(posedge clk_i) begin
    if (acc) rd_q <= line_mem[col_q];
    if (b_valid_q) line_mem[b_col_q] <= {rd_q[PIX_W-1:0], b_px_q};
  end

  // Slide the window one column left
  always_comb begin
    win_s    = win_q;
    win_s[0] = win_q[1];
    win_s[1] = win_q[2];
    win_s[2] = rd_q[2*PIX_W-1:PIX_W];
    win_s[3] = win_q[4];
    win_s[4] = win_q[5];
    win_s[5] = rd_q[PIX_W-1:0];
    win_s[6] = win_q[7];
    win_s[7] = win_q[8];
    win_s[8] = b_px_q;
  end

  assign top    = (b_row_q == '0);
  assign mid    = (32'(b_row_q) >= 2) && (b_col_q != '0);
  assign bot    = (b_row_q == hlast_q) && (b_row_q != '0) && (b_col_q != '0);
  assign at_end = (b_col_q == wlast_q);

  always_comb begin
    desc_o.code  = (32'(b_col_q) >= 2) ? lbp_code(win_s) : '0;
    desc_o.row   = POS_W'(b_row_q);
    desc_o.col   = POS_W'(b_col_q);
    desc_o.slots = '0;
    desc_o.slots[SLOT_ABOVE_PREV] = mid;
    desc_o.slots[SLOT_ABOVE_END]  = mid && at_end;
    desc_o.slots[SLOT_LAST_PREV]  = bot;
    desc_o.slots[SLOT_CUR]        = top || (bot && at_end);
  end

  assign push_o = b_valid_q && (desc_o.slots != '0);

`ifndef NO_ASSERTIONS
  a_stage_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> $past(in_valid_i && in_ready_o))
    else $error("front stage valid without an accepted item");
`endif

endmodule

// ===== hw/rtl/lbp_queue.sv =====
// ----------------------------------------------------------------------------
// LBP descriptor queue
// Short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module lbp_queue
  import lbp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  desc_t     desc_i,
  input  logic      pop_i,
  output desc_t     head_o,
  output q_status_t stat_o
);

  desc_t            mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]   count_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == QCW'(QDEPTH));
  assign stat_o.afull = (count_q >= QCW'(QDEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QAW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QAW'(1);
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCW'(1);
        2'b01:   count_q <= count_q - QCW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= desc_i;
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from an empty queue");
`endif

endmodule

// ===== hw/rtl/lbp_back.sv =====
// ----------------------------------------------------------------------------
// LBP back end
// Expands each descriptor into its result items, one per cycle while the
// output register is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module lbp_back
  import lbp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  desc_t            head_i,
  input  q_status_t        q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] code_o,
  output logic [POS_W-1:0] out_row_o,
  output logic [POS_W-1:0] out_col_o,
  output logic             last_of_run_o
);

  desc_t                cur_q;
  logic                 cur_valid_q;
  logic [NUM_SLOTS-1:0] rem_q;
  logic [NUM_SLOTS-1:0] low, rem_next;
  logic                 out_valid_q;
  logic                 can_emit, emit, finish, load;
  logic                 above, prev;

  assign can_emit = !out_valid_q || out_ready_i;
  assign emit     = cur_valid_q && can_emit;
  assign low      = rem_q & (~rem_q + NUM_SLOTS'(1));
  assign rem_next = rem_q & ~low;
  assign finish   = emit && (rem_next == '0);
  assign load     = !q_stat_i.empty && (!cur_valid_q || finish);
  assign pop_o    = load;

  assign above = low[SLOT_ABOVE_PREV] || low[SLOT_ABOVE_END];
  assign prev  = low[SLOT_ABOVE_PREV] || low[SLOT_LAST_PREV];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= 1'b1;
        rem_q       <= head_i.slots;
      end else if (finish) begin
        cur_valid_q <= 1'b0;
        rem_q       <= '0;
      end else if (emit) begin
        rem_q       <= rem_next;
      end
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= head_i;
    if (emit) begin
      code_o        <= low[SLOT_ABOVE_PREV] ? cur_q.code : '0;
      out_row_o     <= above ? cur_q.row - POS_W'(1) : cur_q.row;
      out_col_o     <= prev ? cur_q.col - POS_W'(1) : cur_q.col;
      last_of_run_o <= (rem_next == '0);
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_busy_has_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (rem_q != '0))
    else $error("active descriptor with no pending result");
`endif

endmodule

// ===== hw/rtl/lbp_3x3_image_stream_core.sv =====
// ----------------------------------------------------------------------------
// LBP 3x3 image stream core
// 8-neighbour local binary pattern over a raster pixel stream, tagged results.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the in_* channel (valid/ready). Results
//   leave on the out_* channel as {code, row, col, last_of_run}; each pixel
//   causes zero to four results, the last one flagged by last_of_run_o.
//   Registers frame_width (index 0) and frame_height (index 1) are written via
//   cfg_we_i; the user must do so only while the core is idle (not enforced).
//   Any valid write restarts the frame. Throughput: one pixel per cycle while
//   each pixel causes at most one result and the receiver keeps up. Row ends
//   from the third row on cause two results; every last-row pixel but the
//   first causes two (four at its end) in frames of three rows or more. The
//   back end emits one result per cycle unless stalled, so the queue absorbs
//   single row ends and the input runs at about half rate across the last row.
//   The line store has one read and one write port, used once per pixel.
//   Reset: position returns to row 0, col 0, window clears, sizes go to
//   640x480. The line store is not cleared and needs no clearing pass.
//   A stalled receiver holds the output register; the descriptor queue
//   (four entries) fills, and in_ready_o drops once it is almost full.
// ----------------------------------------------------------------------------
module lbp_3x3_image_stream_core
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Pixel input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIX_W-1:0]      pixel_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIX_W-1:0]      code_o,
  output logic [POS_W-1:0]      out_row_o,
  output logic [POS_W-1:0]      out_col_o,
  output logic                  last_of_run_o
);

  // Front to queue
  logic      push;
  desc_t     push_desc;
  // Queue to back
  logic      pop;
  desc_t     head_desc;
  q_status_t q_stat;

  // Front: line store, window and classification of each pixel into a
  // descriptor listing which border/interior results it causes.
  lbp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_i     (pixel_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  // Queue: decouples pixel intake from result bursts at row ends.
  lbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (push_desc),
    .pop_i  (pop),
    .head_o (head_desc),
    .stat_o (q_stat)
  );

  // Back: one result item per cycle into the output register, while not stalled.
  lbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_desc),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_o        (code_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== verif/lbp_3x3_image_stream_core_tb.sv =====
// ----------------------------------------------------------------------------
// LBP 3x3 image stream core testbench
// Streams raster pixels through the core under several frame sizes, predicts
// every tagged code from its own line stores and window, and compares each
// result field by field, mostly while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module lbp_3x3_image_stream_core_tb;
  import lbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W            = 1024;
  localparam int MAX_H            = 1024;
  localparam int RANDOM_ITEMS     = 100;
  localparam int WIDE_ROW_PIXELS  = 48;
  localparam int SETTLE_CYCLES    = 10;
  localparam int LONG_HOLD_CYCLES = 90;
  localparam longint TIMEOUT_NS   = 5_000_000;

  // Register indexes the core must ignore
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef enum int {PIX_FULL, PIX_NEAR, PIX_EXTREME} pix_style_e;

  typedef struct {
    logic [PIX_W-1:0] code;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } lbp_result_t;

  // DUT connections, inputs all known from time zero
  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  pix_valid = 1'b0;
  logic                  pix_ready;
  logic [PIX_W-1:0]      pix_data  = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic [PIX_W-1:0]      res_code;
  logic [POS_W-1:0]      res_row;
  logic [POS_W-1:0]      res_col;
  logic                  res_last;

  // Stimulus and checking state
  logic [PIX_W-1:0] pixel_backlog [$];
  lbp_result_t      lbp_expected [$];
  lbp_result_t      code_seen;
  int unsigned      mismatch_count = 0;
  int unsigned      gap_left       = 0;
  int unsigned      stall_left     = 0;
  int unsigned      hold_left      = 0;
  bit               calm           = 1'b0;
  bit               hold_req       = 1'b0;
  bit               hold_done      = 1'b0;

  // Predictor copy of the core: raw registers, position, line stores, window
  logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(FRAME_WIDTH_RST);
  logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(FRAME_HEIGHT_RST);
  int unsigned           frame_row  = 0;
  int unsigned           frame_col  = 0;
  bit [PIX_W-1:0]        hist_one [MAX_W];
  bit [PIX_W-1:0]        hist_two [MAX_W];
  bit [PIX_W-1:0]        tap [9];

  logic [PIX_W-1:0] contrast_frame [9] = '{8'd0,   8'd255, 8'd0,
                                           8'd255, 8'd128, 8'd127,
                                           8'd128, 8'd0,   8'd255};

  lbp_3x3_image_stream_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (pix_valid),
    .in_ready_o    (pix_ready),
    .pixel_i       (pix_data),
    .out_valid_o   (res_valid),
    .out_ready_i   (res_ready),
    .code_o        (res_code),
    .out_row_o     (res_row),
    .out_col_o     (res_col),
    .last_of_run_o (res_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Sizes as the core uses them
  function automatic int unsigned clamp_width(logic [CFG_DATA_W-1:0] raw);
    if (raw < 3) return 3;
    if (raw > MAX_W) return MAX_W;
    return raw;
  endfunction

  function automatic int unsigned clamp_height(logic [CFG_DATA_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > MAX_H) return MAX_H;
    return raw;
  endfunction

  // Window slot that feeds each code bit, bit0 top-left clockwise to bit7 left
  function automatic int unsigned ring_slot(int unsigned bit_idx);
    case (bit_idx)
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 5;
      4: return 8;
      5: return 7;
      6: return 6;
      default: return 3;
    endcase
  endfunction

  function automatic void push_expect(logic [PIX_W-1:0] code, int unsigned row,
                                      int unsigned col, bit is_last);
    lbp_result_t item;
    item.code = code;
    item.row  = POS_W'(row);
    item.col  = POS_W'(col);
    item.last = is_last;
    lbp_expected.push_back(item);
  endfunction

  // Advance the predicted core by one pixel and queue the codes it releases
  function automatic void predict_pixel(logic [PIX_W-1:0] px);
    int unsigned      w;
    int unsigned      h;
    int unsigned      r;
    int unsigned      c;
    int unsigned      left;
    bit [PIX_W-1:0]   up2;
    bit [PIX_W-1:0]   up1;
    logic [PIX_W-1:0] code;
    bit               top_hit;
    bit               mid_hit;
    bit               mid_end;
    bit               bot_hit;
    bit               bot_end;
    w = clamp_width(width_reg);
    h = clamp_height(height_reg);
    r = frame_row;
    c = frame_col;

    up2 = hist_two[c];
    up1 = hist_one[c];
    hist_two[c] = up1;
    hist_one[c] = px;

    // shift the window left, newest column enters on the right
    tap[0] = tap[1]; tap[1] = tap[2];
    tap[3] = tap[4]; tap[4] = tap[5];
    tap[6] = tap[7]; tap[7] = tap[8];
    tap[2] = up2;
    tap[5] = up1;
    tap[8] = px;

    code = '0;
    if (c >= 2 && c <= w - 1) begin
      for (int unsigned k = 0; k < 8; k++) begin
        code[k] = (tap[ring_slot(k)] >= tap[4]);
      end
    end

    top_hit = (r == 0);
    mid_hit = (r >= 2 && c >= 1);
    mid_end = mid_hit && (c == w - 1);
    bot_hit = (r >= 1 && r == h - 1 && c >= 1);
    bot_end = bot_hit && (c == w - 1);
    left = top_hit + mid_hit + mid_end + bot_hit + bot_end;

    // top row: zero code for the pixel itself
    if (top_hit) begin
      left--;
      push_expect('0, 0, c, left == 0);
    end
    // row above: centre one column back, plus the right border at row end
    if (mid_hit) begin
      left--;
      push_expect(code, r - 1, c - 1, left == 0);
    end
    if (mid_end) begin
      left--;
      push_expect('0, r - 1, w - 1, left == 0);
    end
    // bottom row borders trail the row-above results
    if (bot_hit) begin
      left--;
      push_expect('0, r, c - 1, left == 0);
    end
    if (bot_end) begin
      left--;
      push_expect('0, r, w - 1, left == 0);
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    frame_col = c;
    frame_row = r;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(pix_style_e style, logic [PIX_W-1:0] base);
    case (style)
      PIX_NEAR:    return base + PIX_W'($urandom_range(0, 2));
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endtask

  // Wait until the core is drained, let a result-less tail settle, then write
  task automatic write_frame_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    while (pixel_backlog.size() != 0 || pix_valid || lbp_expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    // a valid index restarts the frame; spare indexes leave everything alone
    if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT) begin
      if (idx == CFG_FRAME_WIDTH) width_reg = value;
      else height_reg = value;
      frame_row = 0;
      frame_col = 0;
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Pixel driver: predict on acceptance, then offer the next item or idle
  always @(posedge clk_i) begin
    if (pix_valid && pix_ready) begin
      predict_pixel(pix_data);
    end
    if (!pix_valid || pix_ready) begin
      if (gap_left != 0) begin
        pix_valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (!calm && pixel_backlog.size() != 0 && $urandom_range(0, 9) == 0) begin
        // start an idle burst, counted down in gap_left
        pix_valid <= 1'b0;
        gap_left  <= $urandom_range(0, 6);
      end else if (pixel_backlog.size() != 0) begin
        pix_valid <= 1'b1;
        pix_data  <= pixel_backlog.pop_front();
      end else begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Result receiver: one long hold-off on request, otherwise short stalls
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      // hold long enough for the descriptor queue to fill and stall the input
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES - 1;
      res_ready <= 1'b0;
    end else if (stall_left != 0) begin
      res_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      res_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      res_ready <= 1'b1;
    end
  end

  // Result monitor: compare each accepted item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_valid && res_ready) begin
      if (lbp_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d col %0d code %02h",
                                  res_row, res_col, res_code));
      end else begin
        code_seen = lbp_expected.pop_front();
        check_field($sformatf("code (%0d,%0d)", code_seen.row, code_seen.col),
                    16'(res_code), 16'(code_seen.code));
        check_field("out_row", 16'(res_row), 16'(code_seen.row));
        check_field("out_col", 16'(res_col), 16'(code_seen.col));
        check_field($sformatf("last_of_run (%0d,%0d)", code_seen.row, code_seen.col),
                    16'(res_last), 16'(code_seen.last));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned           random_sent;
    int unsigned           used_w;
    int unsigned           used_h;
    int unsigned           area;
    int unsigned           burst;
    logic [CFG_DATA_W-1:0] raw_w;
    logic [CFG_DATA_W-1:0] raw_h;
    pix_style_e            style;
    logic [PIX_W-1:0]      base;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest interior frame with mixed, equal and extreme neighbours
    write_frame_reg(CFG_FRAME_WIDTH, 11'd3);
    write_frame_reg(CFG_FRAME_HEIGHT, 11'd3);
    foreach (contrast_frame[i]) pixel_backlog.push_back(contrast_frame[i]);

    // Flat white frame, broken mid-frame by writes to unknown indexes
    repeat (4) pixel_backlog.push_back(8'hFF);
    write_frame_reg(CFG_IDX_SPARE_A, 11'h7FF);
    write_frame_reg(CFG_IDX_SPARE_B, 11'h000);
    repeat (5) pixel_backlog.push_back(8'hFF);

    // Sizes below the limits clamp up to a 3x2 all-border frame
    write_frame_reg(CFG_FRAME_WIDTH, 11'd0);
    write_frame_reg(CFG_FRAME_HEIGHT, 11'd1);
    for (int i = 0; i < 6; i++) pixel_backlog.push_back(8'h80 >> i);

    // Random frames: mostly small whole frames, some cut short by a restart
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      raw_w = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                          : CFG_DATA_W'($urandom_range(3, 12));
      case ($urandom_range(0, 7))
        0:       raw_h = CFG_DATA_W'($urandom_range(0, 1));
        1:       raw_h = CFG_DATA_W'($urandom_range(MAX_H + 1, 2047));
        default: raw_h = CFG_DATA_W'($urandom_range(2, 6));
      endcase
      if ($urandom_range(0, 1)) begin
        write_frame_reg(CFG_FRAME_WIDTH, raw_w);
        write_frame_reg(CFG_FRAME_HEIGHT, raw_h);
      end else begin
        write_frame_reg(CFG_FRAME_HEIGHT, raw_h);
        if ($urandom_range(0, 3) != 0) write_frame_reg(CFG_FRAME_WIDTH, raw_w);
      end
      used_w = clamp_width(width_reg);
      used_h = clamp_height(height_reg);
      area   = used_w * used_h;
      if (used_h > 8) burst = $urandom_range(1, 3 * used_w);
      else if ($urandom_range(0, 3) == 0) burst = $urandom_range(1, area);
      else burst = area * $urandom_range(1, 2);
      style = pix_style_e'($urandom_range(0, 2));
      base  = PIX_W'($urandom_range(0, 253));
      repeat (burst) pixel_backlog.push_back(pick_pixel(style, base));
      random_sent += burst;
    end

    // Start of the widest row, written above the limit, under one long
    // receiver hold-off; the next write cuts the frame short
    write_frame_reg(CFG_FRAME_WIDTH, 11'h7FF);
    write_frame_reg(CFG_FRAME_HEIGHT, 11'd2);
    hold_req = 1'b1;
    repeat (WIDE_ROW_PIXELS) pixel_backlog.push_back(pick_pixel(PIX_FULL, '0));

    // Closing frame with both sides running flat out
    write_frame_reg(CFG_FRAME_WIDTH, 11'd6);
    write_frame_reg(CFG_FRAME_HEIGHT, 11'd4);
    calm = 1'b1;
    repeat (24) pixel_backlog.push_back(pick_pixel(PIX_NEAR, PIX_W'($urandom_range(0, 253))));

    // Drain everything, then watch the tail for stray results
    @(negedge clk_i);
    while (pixel_backlog.size() != 0 || pix_valid || lbp_expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
